// ----- rtl/i2c_mra_pkg.sv -----
// ============================================================================
// i2c_mra_pkg
// Shared types and constants of the I2C master register access block.
// ============================================================================
package i2c_mra_pkg;

    localparam int PH_W = 5;

    typedef enum logic [PH_W-1:0] {
        PH_IDLE            = 5'd0,
        PH_START_SETUP     = 5'd1,
        PH_START_HOLD      = 5'd2,
        PH_B0_DATA_LOW     = 5'd3,
        PH_B0_DATA_HIGH    = 5'd4,
        PH_B0_ACK_WAIT     = 5'd5,
        PH_B0_ACK_HIGH     = 5'd6,
        PH_B1_DATA_LOW     = 5'd7,
        PH_B1_DATA_HIGH    = 5'd8,
        PH_B1_ACK_WAIT     = 5'd9,
        PH_B1_ACK_HIGH     = 5'd10,
        PH_B2_DATA_LOW     = 5'd11,
        PH_B2_DATA_HIGH    = 5'd12,
        PH_B2_ACK_WAIT     = 5'd13,
        PH_B2_ACK_HIGH     = 5'd14,
        PH_B3_DATA_LOW     = 5'd15,
        PH_B3_DATA_HIGH    = 5'd16,
        PH_B3_ACK_WAIT     = 5'd17,
        PH_B3_ACK_HIGH     = 5'd18,
        PH_RESTART_RELEASE = 5'd19,
        PH_RESTART_SETUP   = 5'd20,
        PH_RESTART_HOLD    = 5'd21,
        PH_READ_LOW        = 5'd22,
        PH_READ_HIGH       = 5'd23,
        PH_NACK_LOW        = 5'd24,
        PH_NACK_HIGH       = 5'd25,
        PH_STOP_LOW        = 5'd26,
        PH_STOP_HIGH       = 5'd27,
        PH_STOP_RELEASE    = 5'd28
    } phase_t;

    typedef enum logic [1:0] {
        REQ_NONE      = 2'd0,
        REQ_CMD_WRITE = 2'd1,
        REQ_REG_WRITE = 2'd2,
        REQ_REG_READ  = 2'd3
    } req_type_t;

    typedef enum logic [1:0] {
        SUB_DATA_LOW  = 2'd0,
        SUB_DATA_HIGH = 2'd1,
        SUB_ACK_WAIT  = 2'd2,
        SUB_ACK_HIGH  = 2'd3
    } byte_sub_t;

    typedef enum logic [1:0] {
        BYTE_SLAVE    = 2'd0,
        BYTE_REGISTER = 2'd1,
        BYTE_DATA     = 2'd2,
        BYTE_READ_ADR = 2'd3
    } byte_idx_t;

    typedef enum logic {
        CFG_HALF_PERIOD = 1'b0,
        CFG_ACK_TIMEOUT = 1'b1
    } cfg_idx_t;

    localparam logic [7:0] HALF_PERIOD_RESET = 8'd5;
    localparam logic [7:0] ACK_TIMEOUT_RESET = 8'd200;
    localparam logic [3:0] BITS_PER_BYTE     = 4'd8;

    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] dev_addr;
        logic [7:0] reg_addr;
        logic [7:0] write_data;
        logic       sda_in;
    } req_beat_t;

    typedef struct packed {
        logic       scl_out;
        logic       sda_out;
        logic       busy_res;
        logic       done_res;
        logic [7:0] read_data;
        logic       ack_missing;
    } res_beat_t;

endpackage

// ----- rtl/i2c_mra_req_if.sv -----
// ============================================================================
// i2c_mra_req_if
// Request channel: one tick beat with the sampled SDA level and a request.
// ============================================================================
interface i2c_mra_req_if;

    logic       valid;
    logic       ready;
    logic [1:0] req_type;
    logic [7:0] dev_addr;
    logic [7:0] reg_addr;
    logic [7:0] write_data;
    logic       sda_in;

    modport source (
        output valid,
        output req_type,
        output dev_addr,
        output reg_addr,
        output write_data,
        output sda_in,
        input  ready
    );

    modport sink (
        input  valid,
        input  req_type,
        input  dev_addr,
        input  reg_addr,
        input  write_data,
        input  sda_in,
        output ready
    );

endinterface

// ----- rtl/i2c_mra_res_if.sv -----
// ============================================================================
// i2c_mra_res_if
// Result channel: line drives and status for one tick beat.
// ============================================================================
interface i2c_mra_res_if;

    logic       valid;
    logic       ready;
    logic       scl_out;
    logic       sda_out;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_data;
    logic       ack_missing;

    modport source (
        output valid,
        output scl_out,
        output sda_out,
        output busy_res,
        output done_res,
        output read_data,
        output ack_missing,
        input  ready
    );

    modport sink (
        input  valid,
        input  scl_out,
        input  sda_out,
        input  busy_res,
        input  done_res,
        input  read_data,
        input  ack_missing,
        output ready
    );

endinterface

// ----- rtl/i2c_mra_seq.sv -----
// ============================================================================
// i2c_mra_seq
// Bus phase sequencer: advances the I2C transfer by one tick per step.
// ============================================================================
module i2c_mra_seq (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   step,
    input  i2c_mra_pkg::req_beat_t beat,
    input  logic [7:0]             half_period_ticks,
    input  logic [7:0]             ack_timeout_ticks,
    output i2c_mra_pkg::res_beat_t res
);
    import i2c_mra_pkg::*;

    phase_t     phase_reg,    phase_next;
    logic [7:0] tick_reg,     tick_next;
    logic [3:0] bit_cnt_reg,  bit_cnt_next;
    logic [7:0] shift_reg,    shift_next;
    logic [7:0] wait_reg,     wait_next;
    logic [7:0] slave_reg,    slave_next;
    logic [7:0] register_reg, register_next;
    logic [7:0] data_reg,     data_next;
    req_type_t  op_reg,       op_next;
    logic [7:0] rx_reg,       rx_next;
    logic       err_reg,      err_next;

    logic       scl;
    logic       sda;
    logic       elapsed;
    logic [7:0] half_eff;
    logic [8:0] tick_inc;
    logic [4:0] byte_off;
    byte_idx_t  byte_k;
    byte_sub_t  byte_sub;
    logic       in_byte;
    logic [3:0] bit_cnt_inc;
    logic [7:0] rx_shift;

    assign half_eff    = (half_period_ticks == 8'd0) ? 8'd1 : half_period_ticks;
    assign tick_inc    = {1'b0, tick_reg} + 9'd1;
    assign elapsed     = tick_inc >= {1'b0, half_eff};
    assign byte_off    = phase_reg - PH_B0_DATA_LOW;
    assign byte_k      = byte_idx_t'(byte_off[3:2]);
    assign byte_sub    = byte_sub_t'(byte_off[1:0]);
    assign in_byte     = phase_reg inside {[PH_B0_DATA_LOW:PH_B3_ACK_HIGH]};
    assign bit_cnt_inc = bit_cnt_reg + 4'd1;
    assign rx_shift    = {shift_reg[6:0], beat.sda_in};

    // next state
    always_comb
    begin
        phase_next    = phase_reg;
        tick_next     = tick_reg;
        bit_cnt_next  = bit_cnt_reg;
        shift_next    = shift_reg;
        wait_next     = wait_reg;
        slave_next    = slave_reg;
        register_next = register_reg;
        data_next     = data_reg;
        op_next       = op_reg;
        rx_next       = rx_reg;
        err_next      = err_reg;

        if (in_byte)
        begin
            case (byte_sub)
                SUB_DATA_LOW:
                begin
                    tick_next = elapsed ? 8'd0 : tick_inc[7:0];
                    if (elapsed)
                    begin
                        phase_next = phase_t'(phase_reg + 5'd1);
                    end
                end
                SUB_DATA_HIGH:
                begin
                    tick_next = elapsed ? 8'd0 : tick_inc[7:0];
                    if (elapsed)
                    begin
                        shift_next = {shift_reg[6:0], 1'b0};
                        if (bit_cnt_inc >= BITS_PER_BYTE)
                        begin
                            bit_cnt_next = 4'd0;
                            wait_next    = 8'd0;
                            phase_next   = phase_t'(phase_reg + 5'd1);
                        end
                        else
                        begin
                            bit_cnt_next = bit_cnt_inc;
                            phase_next   = phase_t'(phase_reg - 5'd1);
                        end
                    end
                end
                SUB_ACK_WAIT:
                begin
                    if (!beat.sda_in)
                    begin
                        tick_next  = 8'd0;
                        phase_next = phase_t'(phase_reg + 5'd1);
                    end
                    else if (wait_reg >= ack_timeout_ticks)
                    begin
                        tick_next  = 8'd0;
                        err_next   = 1'b1;
                        phase_next = PH_STOP_LOW;
                    end
                    else
                    begin
                        wait_next = wait_reg + 8'd1;
                    end
                end
                default:
                begin
                    tick_next = elapsed ? 8'd0 : tick_inc[7:0];
                    if (elapsed)
                    begin
                        case (byte_k)
                            BYTE_SLAVE:
                            begin
                                phase_next   = PH_B1_DATA_LOW;
                                shift_next   = register_reg;
                                bit_cnt_next = 4'd0;
                            end
                            BYTE_REGISTER:
                            begin
                                if (op_reg == REQ_REG_WRITE)
                                begin
                                    phase_next   = PH_B2_DATA_LOW;
                                    shift_next   = data_reg;
                                    bit_cnt_next = 4'd0;
                                end
                                else if (op_reg == REQ_REG_READ)
                                begin
                                    phase_next = PH_RESTART_RELEASE;
                                end
                                else
                                begin
                                    phase_next = PH_STOP_LOW;
                                end
                            end
                            BYTE_DATA:
                            begin
                                phase_next = PH_STOP_LOW;
                            end
                            default:
                            begin
                                phase_next   = PH_READ_LOW;
                                bit_cnt_next = 4'd0;
                                shift_next   = 8'd0;
                            end
                        endcase
                    end
                end
            endcase
        end
        else
        begin
            case (phase_reg)
                PH_START_SETUP, PH_RESTART_RELEASE, PH_RESTART_SETUP,
                PH_READ_LOW, PH_NACK_LOW, PH_NACK_HIGH,
                PH_STOP_LOW, PH_STOP_HIGH, PH_STOP_RELEASE:
                begin
                    tick_next = elapsed ? 8'd0 : tick_inc[7:0];
                    if (elapsed)
                    begin
                        case (phase_reg)
                            PH_NACK_HIGH:    phase_next = PH_STOP_LOW;
                            PH_STOP_RELEASE: phase_next = PH_IDLE;
                            default:         phase_next = phase_t'(phase_reg + 5'd1);
                        endcase
                    end
                end
                PH_START_HOLD:
                begin
                    tick_next = elapsed ? 8'd0 : tick_inc[7:0];
                    if (elapsed)
                    begin
                        phase_next   = PH_B0_DATA_LOW;
                        shift_next   = slave_reg;
                        bit_cnt_next = 4'd0;
                    end
                end
                PH_RESTART_HOLD:
                begin
                    tick_next = elapsed ? 8'd0 : tick_inc[7:0];
                    if (elapsed)
                    begin
                        phase_next   = PH_B3_DATA_LOW;
                        shift_next   = slave_reg + 8'd1;
                        bit_cnt_next = 4'd0;
                    end
                end
                PH_READ_HIGH:
                begin
                    tick_next = elapsed ? 8'd0 : tick_inc[7:0];
                    if (elapsed)
                    begin
                        shift_next = rx_shift;
                        if (bit_cnt_inc >= BITS_PER_BYTE)
                        begin
                            bit_cnt_next = 4'd0;
                            rx_next      = rx_shift;
                            phase_next   = PH_NACK_LOW;
                        end
                        else
                        begin
                            bit_cnt_next = bit_cnt_inc;
                            phase_next   = PH_READ_LOW;
                        end
                    end
                end
                default:
                begin
                    tick_next  = 8'd0;
                    phase_next = PH_IDLE;
                    if (beat.req_type != REQ_NONE)
                    begin
                        op_next       = req_type_t'(beat.req_type);
                        slave_next    = beat.dev_addr;
                        register_next = beat.reg_addr;
                        data_next     = beat.write_data;
                        err_next      = 1'b0;
                        wait_next     = 8'd0;
                        bit_cnt_next  = 4'd0;
                        phase_next    = PH_START_SETUP;
                    end
                end
            endcase
        end
    end

    // line drives
    always_comb
    begin
        scl = 1'b1;
        sda = 1'b1;
        if (in_byte)
        begin
            case (byte_sub)
                SUB_DATA_LOW:
                begin
                    scl = 1'b0;
                    sda = shift_reg[7];
                end
                SUB_DATA_HIGH:
                begin
                    sda = shift_reg[7];
                end
                SUB_ACK_WAIT:
                begin
                    scl = 1'b0;
                end
                default:
                begin
                    scl = 1'b1;
                end
            endcase
        end
        else
        begin
            case (phase_reg)
                PH_START_HOLD, PH_RESTART_HOLD, PH_STOP_HIGH:
                begin
                    sda = 1'b0;
                end
                PH_RESTART_RELEASE, PH_READ_LOW, PH_NACK_LOW:
                begin
                    scl = 1'b0;
                end
                PH_STOP_LOW:
                begin
                    scl = 1'b0;
                    sda = 1'b0;
                end
                default:
                begin
                    scl = 1'b1;
                end
            endcase
        end
    end

    assign res.scl_out     = scl;
    assign res.sda_out     = sda;
    assign res.busy_res    = phase_next != PH_IDLE;
    assign res.done_res    = (phase_reg == PH_STOP_RELEASE) && elapsed;
    assign res.read_data   = rx_next;
    assign res.ack_missing = err_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_IDLE;
            tick_reg     <= 8'd0;
            bit_cnt_reg  <= 4'd0;
            shift_reg    <= 8'd0;
            wait_reg     <= 8'd0;
            slave_reg    <= 8'd0;
            register_reg <= 8'd0;
            data_reg     <= 8'd0;
            op_reg       <= REQ_NONE;
            rx_reg       <= 8'd0;
            err_reg      <= 1'b0;
        end
        else if (step)
        begin
            phase_reg    <= phase_next;
            tick_reg     <= tick_next;
            bit_cnt_reg  <= bit_cnt_next;
            shift_reg    <= shift_next;
            wait_reg     <= wait_next;
            slave_reg    <= slave_next;
            register_reg <= register_next;
            data_reg     <= data_next;
            op_reg       <= op_next;
            rx_reg       <= rx_next;
            err_reg      <= err_next;
        end
    end

`ifndef ASSERT_OFF
    a_bit_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        bit_cnt_reg < BITS_PER_BYTE)
        else $error("bit counter out of range");

    a_request_starts: assert property (@(posedge clk) disable iff (!rst_n)
        step && (phase_reg == PH_IDLE) && (beat.req_type != REQ_NONE)
        |=> phase_reg == PH_START_SETUP)
        else $error("accepted request did not start a transfer");

    a_done_ends: assert property (@(posedge clk) disable iff (!rst_n)
        step && res.done_res |=> phase_reg == PH_IDLE)
        else $error("transfer done but sequencer not idle");
`endif

endmodule

// ----- rtl/i2c_master_register_access.sv -----
// ============================================================================
// i2c_master_register_access
// Bit-level I2C master for command writes, register writes and register reads.
// ============================================================================
// Each request beat is one bus tick and yields exactly one result beat with
// the SCL/SDA drives for that tick and the transfer status. One beat is taken
// every clock cycle; the result appears in the cycle after acceptance in an
// output register, and a new tick is accepted in the same cycle that the
// previous result is taken, while a stalled result holds off the input. The
// per-tick phase sequencer and its one-tick state update set that rate.
// User writes timing registers via the cfg port only while idle; not enforced.
module i2c_master_register_access (
    input  logic             clk,
    input  logic             rst_n,
    i2c_mra_req_if.sink      req,
    i2c_mra_res_if.source    res,
    input  logic             cfg_we,
    input  logic             cfg_index,
    input  logic [7:0]       cfg_data
);
    import i2c_mra_pkg::*;

    logic [7:0] half_period_reg;
    logic [7:0] ack_timeout_reg;
    logic       out_valid_reg;
    res_beat_t  out_reg;
    req_beat_t  in_beat;
    res_beat_t  seq_res;
    logic       accept;

    assign req.ready = !out_valid_reg || res.ready;
    assign accept    = req.valid && req.ready;

    assign in_beat.req_type   = req.req_type;
    assign in_beat.dev_addr   = req.dev_addr;
    assign in_beat.reg_addr   = req.reg_addr;
    assign in_beat.write_data = req.write_data;
    assign in_beat.sda_in     = req.sda_in;

    i2c_mra_seq u_seq (
        .clk               (clk),
        .rst_n             (rst_n),
        .step              (accept),
        .beat              (in_beat),
        .half_period_ticks (half_period_reg),
        .ack_timeout_ticks (ack_timeout_reg),
        .res               (seq_res)
    );

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_period_reg <= HALF_PERIOD_RESET;
            ack_timeout_reg <= ACK_TIMEOUT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_HALF_PERIOD: half_period_reg <= cfg_data;
                CFG_ACK_TIMEOUT: ack_timeout_reg <= cfg_data;
                default:         half_period_reg <= half_period_reg;
            endcase
        end
    end

    // result beat register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (res.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_reg <= seq_res;
        end
    end

    assign res.valid       = out_valid_reg;
    assign res.scl_out     = out_reg.scl_out;
    assign res.sda_out     = out_reg.sda_out;
    assign res.busy_res    = out_reg.busy_res;
    assign res.done_res    = out_reg.done_res;
    assign res.read_data   = out_reg.read_data;
    assign res.ack_missing = out_reg.ack_missing;

`ifndef ASSERT_OFF
    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.done_res |-> !res.busy_res)
        else $error("done beat reports busy");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && !res.ready |=> res.valid && $stable(out_reg))
        else $error("stalled result beat changed");

    a_one_per_beat: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> out_valid_reg)
        else $error("accepted tick produced no result beat");
`endif

endmodule
